// File: rtl/bmf_pkg.sv
`default_nettype none
package bmf_pkg;

  localparam int MaxKernel  = 7;
  localparam int MaxWidth   = 2048;
  localparam int Channels   = 3;
  localparam int RingRows   = MaxKernel + 1;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int CntW       = ColW + 1;
  localparam int SlotW      = $clog2(RingRows);
  localparam int KW         = 3;
  localparam int SumW       = 14;

  localparam logic [1:0] CFG_KERNEL   = 2'd0;
  localparam logic [1:0] CFG_WIDTH    = 2'd1;
  localparam logic [1:0] CFG_HEIGHT   = 2'd2;
  localparam logic [1:0] CFG_CHANNELS = 2'd3;

  typedef struct packed {
    logic       mode;
    logic [7:0] sample_a;
    logic [7:0] sample_b;
    logic [7:0] sample_c;
  } in_item_t;

  typedef struct packed {
    logic [7:0] mean_a;
    logic [7:0] mean_b;
    logic [7:0] mean_c;
    logic       frame_end;
  } out_item_t;

  // reciprocal of k*k for k in 1,3,5,7; scaled by 2^24, rounded up
  function automatic logic [24:0] recip(input logic [KW-1:0] k);
    logic [24:0] r;
    case (k)
      3'd3:    r = 25'd1864136;
      3'd5:    r = 25'd671089;
      3'd7:    r = 25'd342393;
      default: r = 25'd16777216;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] ksq(input logic [KW-1:0] k);
    logic [6:0] r;
    case (k)
      3'd3:    r = 7'd9;
      3'd5:    r = 7'd25;
      3'd7:    r = 7'd49;
      default: r = 7'd1;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/box_mean_filter_zero_pad.sv
`default_nettype none
// Flow: the request that completes a window starts the line-store reads of its k*k taps;
//   the read data is registered, then one divide step registers the output.
// Pacing: a new request is taken only in the idle state, once the last one is through;
//   the single read port sets this. A held output stalls the divide.
// Reset: synchronous active low; registers return to 3/640/480/3, positions to
//   zero. The line store is not cleared; the window only reads written rows.
module box_mean_filter_zero_pad import bmf_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [11:0] cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SUM  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  // ring of image rows, three channels per entry
  logic [23:0] line_mem [RingRows*MaxWidth];
  logic [23:0] rd_data_r;

  logic [KW-1:0] kreg_r;
  logic [11:0]   wreg_r, hreg_r;
  logic [1:0]    chreg_r;

  logic [CntW-1:0] in_row_r, in_col_r, out_row_r, out_col_r;
  logic [1:0]      state_r;
  logic [KW-1:0]   dr_r, dc_r;
  logic            rd_ok_r, last_r;
  logic [SumW-1:0] acc_r [3];
  logic            ov_r;
  out_item_t       od_r;

  // effective settings
  logic [KW-1:0]   k, p;
  logic [CntW-1:0] w, h;
  logic [1:0]      nch;
  always_comb begin
    k = (kreg_r[0]) ? kreg_r : ((kreg_r == 3'd0) ? 3'd1 : kreg_r - 3'd1);
    p = k >> 1;
    w = (wreg_r == 12'd0) ? CntW'(1)
        : ((wreg_r > 12'(MaxWidth)) ? CntW'(MaxWidth) : CntW'(wreg_r));
    h = (hreg_r == 12'd0) ? CntW'(1) : CntW'(hreg_r);
    nch = (chreg_r == 2'd0) ? 2'd1 : chreg_r;
  end

  logic [CntW:0] need_r, need_c;
  logic          ready_out, done_in;
  always_comb begin
    need_r = {1'b0, out_row_r} + (CntW+1)'(p);
    if (need_r > {1'b0, h - CntW'(1)}) need_r = {1'b0, h - CntW'(1)};
    need_c = {1'b0, out_col_r} + (CntW+1)'(p);
    if (need_c > {1'b0, w - CntW'(1)}) need_c = {1'b0, w - CntW'(1)};
    ready_out = ({1'b0, in_row_r} > need_r) ||
                ({1'b0, in_row_r} == need_r && {1'b0, in_col_r} > need_c);
    done_in = in_row_r >= h;
  end

  // the pixel written by an item counts before the window check
  logic [CntW-1:0] ir_n, ic_n;
  logic            wr_px;
  always_comb begin
    wr_px = !in_data.mode && !done_in;
    ir_n = in_row_r;
    ic_n = in_col_r;
    if (wr_px) begin
      ic_n = in_col_r + CntW'(1);
      if (ic_n >= w) begin
        ic_n = '0;
        ir_n = in_row_r + CntW'(1);
      end
    end
  end

  // a pending output holds the divide step and register writes, not the next request
  logic div_go;
  assign div_go    = (state_r == ST_DIV) && (!ov_r || out_ready);
  assign in_ready  = (state_r == ST_IDLE) && !cfg_valid;
  assign cfg_ready = (state_r == ST_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  // window address
  logic signed [CntW+1:0] r_s, c_s;
  logic                   in_win;
  logic [SlotW+ColW-1:0]  rd_addr;
  always_comb begin
    r_s = $signed({2'b0, out_row_r}) + $signed({{(CntW-1){1'b0}}, dr_r})
          - $signed({{(CntW-1){1'b0}}, p});
    c_s = $signed({2'b0, out_col_r}) + $signed({{(CntW-1){1'b0}}, dc_r})
          - $signed({{(CntW-1){1'b0}}, p});
    in_win = (r_s >= 0) && (r_s < $signed({2'b0, h})) &&
             (c_s >= 0) && (c_s < $signed({2'b0, w}));
    rd_addr = {r_s[SlotW-1:0], c_s[ColW-1:0]};
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready && wr_px)
      line_mem[{in_row_r[SlotW-1:0], in_col_r[ColW-1:0]}] <=
        {in_data.sample_a, in_data.sample_b, in_data.sample_c};
    rd_data_r <= line_mem[rd_addr];
  end

  logic acc_go;
  logic step_last;
  assign step_last = (dr_r == k - 3'd1) && (dc_r == k - 3'd1);

  logic [SumW+24:0] q [3];
  always_comb begin
    for (int i = 0; i < 3; i++)
      q[i] = ((SumW+25)'(acc_r[i]) * (SumW+25)'(recip(k))) >> 24;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kreg_r <= 3'd3; wreg_r <= 12'd640; hreg_r <= 12'd480; chreg_r <= 2'd3;
      in_row_r <= '0; in_col_r <= '0; out_row_r <= '0; out_col_r <= '0;
      state_r <= ST_IDLE; ov_r <= 1'b0; rd_ok_r <= 1'b0; dr_r <= '0; dc_r <= '0;
      last_r <= 1'b0;
    end else begin
      if (div_go) ov_r <= 1'b1;
      else if (ov_r && out_ready) ov_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_KERNEL:   kreg_r  <= cfg_data[KW-1:0];
          CFG_WIDTH:    wreg_r  <= cfg_data;
          CFG_HEIGHT:   hreg_r  <= cfg_data;
          CFG_CHANNELS: chreg_r <= cfg_data[1:0];
          default: ;
        endcase
        in_row_r <= '0; in_col_r <= '0; out_row_r <= '0; out_col_r <= '0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            in_row_r <= ir_n;
            in_col_r <= ic_n;
            state_r  <= ST_SUM;
            dr_r <= '0; dc_r <= '0; rd_ok_r <= 1'b0; last_r <= 1'b0;
          end
        end
        ST_SUM: begin
          // first cycle decides whether a window is ready
          if (!ready_out) state_r <= ST_IDLE;
          else begin
            rd_ok_r <= in_win;
            last_r  <= step_last;
            if (!last_r || dr_r != '0 || dc_r != '0) begin
              if (dc_r == k - 3'd1) begin
                dc_r <= '0; dr_r <= dr_r + 3'd1;
              end else dc_r <= dc_r + 3'd1;
            end
            if (last_r) state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_go) begin
            state_r <= ST_IDLE;
            if (out_row_r == h - CntW'(1) && out_col_r == w - CntW'(1)) begin
              in_row_r <= '0; in_col_r <= '0; out_row_r <= '0; out_col_r <= '0;
            end else if (out_col_r + CntW'(1) >= w) begin
              out_col_r <= '0; out_row_r <= out_row_r + CntW'(1);
            end else out_col_r <= out_col_r + CntW'(1);
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // accumulate the value read in the previous cycle
  assign acc_go = (state_r == ST_SUM) && ready_out;
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      for (int i = 0; i < 3; i++) acc_r[i] <= '0;
    end else if (acc_go && rd_ok_r && (dr_r != '0 || dc_r != '0 || last_r)) begin
      acc_r[0] <= acc_r[0] + SumW'(rd_data_r[23:16]);
      acc_r[1] <= acc_r[1] + SumW'(rd_data_r[15:8]);
      acc_r[2] <= acc_r[2] + SumW'(rd_data_r[7:0]);
    end
    if (div_go) begin
      od_r.mean_a <= 8'(q[0]);
      od_r.mean_b <= (nch >= 2'd2) ? 8'(q[1]) : 8'd0;
      od_r.mean_c <= (nch >= 2'd3) ? 8'(q[2]) : 8'd0;
      od_r.frame_end <= (out_row_r == h - CntW'(1)) && (out_col_r == w - CntW'(1));
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |=> ov_r && $stable(od_r)) else $error("output dropped");
  a_div_then_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |=> ov_r) else $error("result lost");
  a_mean_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (acc_r[0] < SumW'(256) * SumW'(ksq(k))))
    else $error("sum overflow");
`endif

endmodule
`default_nettype wire

// File: test/testbench.sv
module testbench;
  import bmf_pkg::*;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;
  localparam int   RANDOM_ITEMS = 700;
  // quiet time before a register write: one full window pass plus margin
  localparam int   SETTLE_CYCLES = MaxKernel * MaxKernel + 20;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [11:0] cfg_data;

  box_mean_filter_zero_pad dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Filter shadow: register copies, frame positions and the row ring.
  // ---------------------------------------------------------------------------
  logic [2:0]  sh_kernel;
  logic [11:0] sh_width;
  logic [11:0] sh_height;
  logic [1:0]  sh_chans;
  int          in_r, in_c, out_r, out_c;
  logic [7:0]  row_ring [RingRows][MaxWidth][Channels];

  out_item_t   pending_means[$];
  bit          frame_closed;     // set when the shadow emits frame_end
  bit          calm;             // no idling on either side
  int          n_items, n_results, n_frames, n_cfg, n_errors;

  function automatic int eff_kernel();
    int k;
    k = int'(sh_kernel);
    if (k > MaxKernel) k = MaxKernel;
    if (k % 2 == 0) k = (k == 0) ? 1 : k - 1;
    return k;
  endfunction

  function automatic int eff_width();
    if (sh_width == 0) return 1;
    return (int'(sh_width) > MaxWidth) ? MaxWidth : int'(sh_width);
  endfunction

  function automatic int eff_chans();
    if (sh_chans == 0) return 1;
    return (int'(sh_chans) > Channels) ? Channels : int'(sh_chans);
  endfunction

  function automatic void restart_positions();
    in_r = 0;
    in_c = 0;
    out_r = 0;
    out_c = 0;
  endfunction

  function automatic void shadow_write(logic [1:0] idx, logic [11:0] val);
    case (idx)
      CFG_KERNEL:   sh_kernel = val[2:0];
      CFG_WIDTH:    sh_width  = val;
      CFG_HEIGHT:   sh_height = val;
      CFG_CHANNELS: sh_chans  = val[1:0];
      default: ;
    endcase
    restart_positions();
  endfunction

  // Advance the shadow by one accepted request; returns 1 with the window
  // means when an output becomes ready.
  function automatic bit window_means(in_item_t it, output out_item_t res);
    int k, p, w, h, nch, need_r, need_c, r, c, dr, dc, ch;
    int sum;
    logic [7:0] smp[3];
    k = eff_kernel();
    p = k / 2;
    w = eff_width();
    h = (sh_height == 0) ? 1 : int'(sh_height);
    nch = eff_chans();
    res = '0;
    smp[0] = it.sample_a;
    smp[1] = it.sample_b;
    smp[2] = it.sample_c;
    // pixels past the end of the frame are dropped and behave as flush ticks
    if (it.mode == MODE_PIXEL && in_r < h) begin
      for (ch = 0; ch < Channels; ch++) row_ring[in_r % RingRows][in_c][ch] = smp[ch];
      in_c++;
      if (in_c >= w) begin
        in_c = 0;
        in_r++;
      end
    end
    need_r = (out_r + p > h - 1) ? h - 1 : out_r + p;
    need_c = (out_c + p > w - 1) ? w - 1 : out_c + p;
    if (!(in_r > need_r || (in_r == need_r && in_c > need_c))) return 1'b0;
    for (ch = 0; ch < 3; ch++) begin
      sum = 0;
      if (ch < nch) begin
        // zero padding: off-image taps simply contribute nothing
        for (dr = -p; dr <= p; dr++) begin
          r = out_r + dr;
          if (r < 0 || r >= h) continue;
          for (dc = -p; dc <= p; dc++) begin
            c = out_c + dc;
            if (c < 0 || c >= w) continue;
            sum += row_ring[r % RingRows][c][ch];
          end
        end
        sum = sum / (k * k);
      end
      case (ch)
        0: res.mean_a = sum[7:0];
        1: res.mean_b = sum[7:0];
        default: res.mean_c = sum[7:0];
      endcase
    end
    if (out_r == h - 1 && out_c == w - 1) begin
      res.frame_end = 1'b1;
      restart_positions();
    end else begin
      out_c++;
      if (out_c >= w) begin
        out_c = 0;
        out_r++;
      end
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Send one request; if want_given, the typed result replaces the shadow's.
  task automatic send_request(in_item_t it, bit want_given, out_item_t want);
    out_item_t res;
    int gap;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    n_items++;
    if (window_means(it, res)) begin
      if (res.frame_end) begin
        frame_closed = 1'b1;
        n_frames++;
      end
      pending_means.push_back(want_given ? want : res);
    end else if (want_given) begin
      pending_means.push_back(want);
    end
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Registers change only with nothing in flight.
  task automatic write_reg(logic [1:0] idx, logic [11:0] val);
    in_valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_write(idx, val);
    n_cfg++;
  endtask

  function automatic in_item_t rand_item(logic mode);
    in_item_t it;
    it.mode     = mode;
    it.sample_a = 8'($urandom);
    it.sample_b = 8'($urandom);
    it.sample_c = 8'($urandom);
    return it;
  endfunction

  // Pixels of one frame with stray flush ticks, then a drain; a broken
  // frame stops early and is cut off by the next register write.
  task automatic run_frame(bit broken);
    int total, sent, stop_at;
    total = eff_width() * ((sh_height == 0) ? 1 : int'(sh_height));
    stop_at = broken ? $urandom_range(total - 1, 0) : total;
    frame_closed = 1'b0;
    sent = 0;
    while (sent < stop_at) begin
      if ($urandom_range(9) == 0) begin
        send_request(rand_item(MODE_FLUSH), 1'b0, '0);
      end else begin
        send_request(rand_item(MODE_PIXEL), 1'b0, '0);
        sent++;
      end
    end
    // drain: flush ticks, or pixels that the block drops as flush ticks
    while (!broken && !frame_closed)
      send_request(rand_item($urandom_range(1) ? MODE_FLUSH : MODE_PIXEL), 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Directed table: register writes and requests; typed results where obvious.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    bit          is_reg;
    logic [1:0]  idx;
    logic [11:0] val;
    in_item_t    item;
    bit          typed;
    out_item_t   want;
  } step_row_t;

  step_row_t plan[$];

  function automatic step_row_t reg_row(logic [1:0] idx, logic [11:0] val);
    return '{1'b1, idx, val, '0, 1'b0, '0};
  endfunction

  function automatic step_row_t req_row(logic mode, logic [7:0] a, logic [7:0] b,
                                        logic [7:0] c, bit typed, out_item_t want);
    return '{1'b0, 2'd0, 12'd0, '{mode, a, b, c}, typed, want};
  endfunction

  initial begin
    int i, bigs;
    step_row_t row;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_KERNEL;
    cfg_data  = '0;
    calm      = 1'b0;
    n_items = 0; n_results = 0; n_frames = 0; n_cfg = 0; n_errors = 0;
    for (int r = 0; r < RingRows; r++)
      for (int c = 0; c < MaxWidth; c++)
        for (int ch = 0; ch < Channels; ch++) row_ring[r][c][ch] = '0;
    sh_kernel = 3'd3;
    sh_width  = 12'd640;
    sh_height = 12'd480;
    sh_chans  = 2'd3;
    restart_positions();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one-pixel frames: the mean is the sample over k*k
    plan.push_back(reg_row(CFG_KERNEL, 12'd1));
    plan.push_back(reg_row(CFG_WIDTH, 12'd1));
    plan.push_back(reg_row(CFG_HEIGHT, 12'd1));
    plan.push_back(req_row(MODE_PIXEL, 8'd255, 8'd0, 8'd170, 1'b1, '{8'd255, 8'd0, 8'd170, 1'b1}));
    plan.push_back(req_row(MODE_PIXEL, 8'd0, 8'd255, 8'd85, 1'b1, '{8'd0, 8'd255, 8'd85, 1'b1}));
    // nothing ready: no result
    plan.push_back(req_row(MODE_FLUSH, 8'd255, 8'd255, 8'd255, 1'b0, '0));
    // unused channels read zero; a count of zero acts as one
    plan.push_back(reg_row(CFG_CHANNELS, 12'd1));
    plan.push_back(req_row(MODE_PIXEL, 8'd200, 8'd201, 8'd202, 1'b1, '{8'd200, 8'd0, 8'd0, 1'b1}));
    plan.push_back(reg_row(CFG_CHANNELS, 12'd0));
    plan.push_back(req_row(MODE_PIXEL, 8'd9, 8'd201, 8'd202, 1'b1, '{8'd9, 8'd0, 8'd0, 1'b1}));
    plan.push_back(reg_row(CFG_CHANNELS, 12'd2));
    // 3x3 window around a lone pixel: eight zero-padded taps
    plan.push_back(reg_row(CFG_KERNEL, 12'd3));
    plan.push_back(req_row(MODE_PIXEL, 8'd90, 8'd90, 8'd90, 1'b1, '{8'd10, 8'd10, 8'd0, 1'b1}));
    // even kernel clamps down, zero acts as one
    plan.push_back(reg_row(CFG_KERNEL, 12'd2));
    plan.push_back(req_row(MODE_PIXEL, 8'd7, 8'd8, 8'd9, 1'b1, '{8'd7, 8'd8, 8'd0, 1'b1}));
    plan.push_back(reg_row(CFG_KERNEL, 12'd0));
    plan.push_back(req_row(MODE_PIXEL, 8'd1, 8'd2, 8'd3, 1'b1, '{8'd1, 8'd2, 8'd0, 1'b1}));
    // largest kernel, zero width and height act as one
    plan.push_back(reg_row(CFG_CHANNELS, 12'd3));
    plan.push_back(reg_row(CFG_KERNEL, 12'd7));
    plan.push_back(reg_row(CFG_WIDTH, 12'd0));
    plan.push_back(reg_row(CFG_HEIGHT, 12'd0));
    plan.push_back(req_row(MODE_PIXEL, 8'd255, 8'd255, 8'd255, 1'b1, '{8'd5, 8'd5, 8'd5, 1'b1}));
    // 2x2 frame with k=3, then a pixel during drain; shadow-checked
    plan.push_back(reg_row(CFG_KERNEL, 12'd3));
    plan.push_back(reg_row(CFG_WIDTH, 12'd2));
    plan.push_back(reg_row(CFG_HEIGHT, 12'd2));
    plan.push_back(req_row(MODE_PIXEL, 8'd255, 8'd0, 8'd1, 1'b0, '0));
    plan.push_back(req_row(MODE_PIXEL, 8'd128, 8'd127, 8'd64, 1'b0, '0));
    plan.push_back(req_row(MODE_PIXEL, 8'd3, 8'd254, 8'd32, 1'b0, '0));
    plan.push_back(req_row(MODE_PIXEL, 8'd16, 8'd8, 8'd4, 1'b0, '0));
    plan.push_back(req_row(MODE_PIXEL, 8'd2, 8'd2, 8'd2, 1'b0, '0));
    plan.push_back(req_row(MODE_FLUSH, 8'd0, 8'd0, 8'd0, 1'b0, '0));
    plan.push_back(req_row(MODE_FLUSH, 8'd0, 8'd0, 8'd0, 1'b0, '0));

    foreach (plan[j]) begin
      row = plan[j];
      if (row.is_reg) write_reg(row.idx, row.val);
      else send_request(row.item, row.typed, row.want);
    end

    // Random phases: fresh settings each time, a few larger frames.
    i = 0;
    bigs = 0;
    while (n_items < RANDOM_ITEMS + plan.size()) begin
      calm = ($urandom_range(5) == 0);
      if (i == 6 || i == 14) begin
        // a long row with the largest kernel, and a tall single column
        write_reg(CFG_KERNEL, 12'd7);
        write_reg(CFG_WIDTH, (i == 6) ? 12'd100 : 12'd1);
        write_reg(CFG_HEIGHT, (i == 6) ? 12'd1 : 12'd48);
        write_reg(CFG_CHANNELS, 12'($urandom_range(3)));
        bigs++;
      end else begin
        if ($urandom_range(1)) write_reg(CFG_KERNEL, 12'($urandom_range(7)));
        if ($urandom_range(1)) begin
          write_reg(CFG_WIDTH, ($urandom_range(9) == 0) ? 12'($urandom_range(96, 10))
                                                        : 12'($urandom_range(9)));
        end
        if ($urandom_range(1)) write_reg(CFG_HEIGHT, 12'($urandom_range(7)));
        // always one write, so a cut-off frame never leaks into the next
        write_reg(CFG_CHANNELS, 12'($urandom_range(3)));
      end
      // a width draw above 64 makes a big frame; keep those to a single row
      if (eff_width() > 64 && sh_height > 1 && i != 14) write_reg(CFG_HEIGHT, 12'd1);
      run_frame($urandom_range(7) == 0 && i != 6 && i != 14);
      i++;
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d requests, %0d outputs, %0d frames, %0d register writes",
             n_items, n_results, n_frames, n_cfg);
    $display("random phases: %0d, larger frames: %0d", i, bigs);
    if (n_errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, short stalls mostly, some long ones.
  // ---------------------------------------------------------------------------
  int hold = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
      hold <= 0;
    end else if (hold > 0) begin
      out_ready <= 1'b0;
      hold <= hold - 1;
    end else if ($urandom_range(7) == 0) begin
      out_ready <= 1'b0;
      hold <= ($urandom_range(9) == 0) ? $urandom_range(40, 15) : $urandom_range(3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_item_t exp_means;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (pending_means.size() == 0) begin
        $error("output with no result pending: %h", out_data);
        n_errors++;
      end else begin
        exp_means = pending_means.pop_front();
        if (out_data.mean_a !== exp_means.mean_a) begin
          $error("mean_a: expected %0d, got %0d", exp_means.mean_a, out_data.mean_a);
          n_errors++;
        end
        if (out_data.mean_b !== exp_means.mean_b) begin
          $error("mean_b: expected %0d, got %0d", exp_means.mean_b, out_data.mean_b);
          n_errors++;
        end
        if (out_data.mean_c !== exp_means.mean_c) begin
          $error("mean_c: expected %0d, got %0d", exp_means.mean_c, out_data.mean_c);
          n_errors++;
        end
        if (out_data.frame_end !== exp_means.frame_end) begin
          $error("frame_end: expected %0d, got %0d", exp_means.frame_end,
                 out_data.frame_end);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #100000000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
